@@ design/sft_pkg.sv @@
// Package for the score field tokenizer: payload structs, character codes,
// result kinds and configuration register indexes. No dependencies.
`timescale 1ns / 1ps

package sft_pkg;

  localparam int unsigned MaxBraceDepth = 255;
  localparam int unsigned DepthW        = $clog2(MaxBraceDepth + 1);
  localparam int unsigned QueueDepth    = 4;
  localparam int unsigned QPtrW         = $clog2(QueueDepth);
  localparam int unsigned QCntW         = $clog2(QueueDepth + 1);
  localparam int unsigned MaskW         = 128;

  localparam logic [7:0] ChHash  = 8'd35;
  localparam logic [7:0] ChQuote = 8'd34;
  localparam logic [7:0] ChOpen  = 8'd123;
  localparam logic [7:0] ChClose = 8'd125;
  localparam logic [7:0] ChTab   = 8'd9;
  localparam logic [7:0] ChNl    = 8'd10;
  localparam logic [7:0] ChSp    = 8'd32;

  localparam logic [1:0] KindChar  = 2'd0;
  localparam logic [1:0] KindBreak = 2'd1;
  localparam logic [1:0] KindEnd   = 2'd2;

  localparam logic [1:0] CfgBreakLow  = 2'd0;
  localparam logic [1:0] CfgBreakHigh = 2'd1;
  localparam logic [1:0] CfgIgnLow    = 2'd2;
  localparam logic [1:0] CfgIgnHigh   = 2'd3;

  typedef struct packed {
    logic [7:0] in_char;
    logic       end_of_input;
  } in_item_t;

  typedef struct packed {
    logic [1:0] kind;
    logic [7:0] out_char;
    logic       brace_error;
    logic       quote_error;
    logic       last;
  } out_item_t;

  // One queue entry: the results caused by one input character.
  typedef struct packed {
    logic      two;
    out_item_t r0;
    out_item_t r1;
  } rec_t;

  function automatic out_item_t make_res(logic [1:0] kind, logic [7:0] ch,
                                         logic be, logic qe);
    out_item_t r;
    r.kind        = kind;
    r.out_char    = ch;
    r.brace_error = be;
    r.quote_error = qe;
    r.last        = 1'b0;
    return r;
  endfunction

  function automatic logic in_mask(logic [MaskW-1:0] m, logic [7:0] c);
    return c[7] ? 1'b0 : m[c[6:0]];
  endfunction

endpackage

@@ design/sft_front.sv @@
// Front end of the score field tokenizer: accepts characters, holds the
// tokenizer state and the masks, builds a queue record. Uses sft_pkg.
`timescale 1ns / 1ps

module sft_front (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  sft_pkg::in_item_t  in_item_i,
  input  logic               cfg_valid_i,
  input  logic [1:0]         cfg_index_i,
  input  logic [63:0]        cfg_data_i,
  input  logic               q_full_i,
  output logic               q_push_o,
  output sft_pkg::rec_t      q_rec_o
);
  import sft_pkg::*;

  logic [MaskW-1:0]  brk_q, ign_q;
  logic [7:0]        prev_q, prev_d, pchar_q, pchar_d;
  logic              skip_q, skip_d, quote_q, quote_d, start_q, start_d;
  logic              pend_q, pend_d, unbal_q, unbal_d;
  logic [DepthW-1:0] depth_q, depth_d;

  logic              accept;
  logic [7:0]        c, v, lastc;
  logic              do_proc, pc_emit, is_blank;
  out_item_t         pc_res, res0, res1;
  logic [1:0]        n_res;

  assign in_ready_o = !q_full_i;
  assign accept     = in_valid_i && in_ready_o;
  assign c          = in_item_i.in_char;
  assign is_blank   = (c == ChSp) || (c == ChTab) || (c == ChNl);

  always_comb begin
    prev_d  = prev_q;
    pchar_d = pchar_q;
    skip_d  = skip_q;
    quote_d = quote_q;
    start_d = start_q;
    pend_d  = pend_q;
    unbal_d = unbal_q;
    depth_d = depth_q;
    res0    = make_res(KindChar, 8'd0, 1'b0, 1'b0);
    res1    = res0;
    pc_res  = res0;
    n_res   = 2'd0;
    do_proc = 1'b0;
    pc_emit = 1'b0;
    lastc   = prev_q;
    v       = c;

    if (in_item_i.end_of_input) begin
      if (pend_q) begin
        res0   = make_res(KindBreak, pchar_q, 1'b0, 1'b0);
        res1   = make_res(KindEnd, 8'd0, (depth_q != '0) || unbal_q, quote_q);
        n_res  = 2'd2;
        pend_d = 1'b0;
      end else begin
        res0  = make_res(KindEnd, 8'd0, (depth_q != '0) || unbal_q, quote_q);
        n_res = 2'd1;
      end
      start_d = 1'b1;
      skip_d  = 1'b0;
      prev_d  = ChNl;
    end else if (pend_q) begin
      if (is_blank) begin
        pchar_d = c;
      end else begin
        pend_d  = 1'b0;
        start_d = 1'b1;
        n_res   = 2'd1;
        if (in_mask(brk_q, c)) begin
          prev_d = c;
          res0   = make_res(KindBreak, c, 1'b0, 1'b0);
        end else begin
          res0    = make_res(KindBreak, pchar_q, 1'b0, 1'b0);
          do_proc = 1'b1;
        end
      end
    end else begin
      do_proc = 1'b1;
    end

    if (do_proc) begin
      prev_d = c;
      if (skip_q) begin
        if (c == ChNl) skip_d = 1'b0;
      end else if (c == ChHash) begin
        if (lastc == ChNl) skip_d = 1'b1;
      end else if (depth_q == '0 && c == ChQuote) begin
        quote_d = !quote_q;
      end else if (depth_q == '0 && quote_q) begin
        pc_res  = make_res(KindChar, c, 1'b0, 1'b0);
        pc_emit = 1'b1;
        start_d = 1'b0;
      end else begin
        if (c == ChTab || c == ChNl) v = ChSp;
        if (v == ChOpen) begin
          if (depth_q < DepthW'(MaxBraceDepth)) depth_d = depth_q + 1'b1;
        end else if (v == ChClose) begin
          if (depth_q == '0) unbal_d = 1'b1;
          else depth_d = depth_q - 1'b1;
        end else if (depth_q != '0) begin
          // inside a brace comment: dropped
        end else if (start_d && v == ChSp) begin
          // leading blank: dropped
        end else if (in_mask(ign_q, v)) begin
          // ignored code: dropped
        end else if (!in_mask(brk_q, v)) begin
          pc_res  = make_res(KindChar, v, 1'b0, 1'b0);
          pc_emit = 1'b1;
          start_d = 1'b0;
        end else if (v == ChSp) begin
          pend_d  = 1'b1;
          pchar_d = ChSp;
        end else begin
          pc_res  = make_res(KindBreak, v, 1'b0, 1'b0);
          pc_emit = 1'b1;
          start_d = 1'b1;
        end
      end
      if (pc_emit) begin
        if (n_res == 2'd0) res0 = pc_res;
        else res1 = pc_res;
        n_res = n_res + 2'd1;
      end
    end
  end

  always_comb begin
    q_rec_o         = '{two: (n_res == 2'd2), r0: res0, r1: res1};
    q_rec_o.r0.last = (n_res == 2'd1);
    q_rec_o.r1.last = 1'b1;
    q_push_o        = accept && (n_res != 2'd0);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      brk_q   <= MaskW'(1) << 32;
      ign_q   <= '0;
      prev_q  <= ChNl;
      pchar_q <= ChSp;
      skip_q  <= 1'b0;
      quote_q <= 1'b0;
      start_q <= 1'b1;
      pend_q  <= 1'b0;
      unbal_q <= 1'b0;
      depth_q <= '0;
    end else begin
      if (cfg_valid_i) begin
        case (cfg_index_i)
          CfgBreakLow:  brk_q[63:0]   <= cfg_data_i;
          CfgBreakHigh: brk_q[127:64] <= cfg_data_i;
          CfgIgnLow:    ign_q[63:0]   <= cfg_data_i;
          CfgIgnHigh:   ign_q[127:64] <= cfg_data_i;
          default: ;
        endcase
      end
      if (accept) begin
        prev_q  <= prev_d;
        pchar_q <= pchar_d;
        skip_q  <= skip_d;
        quote_q <= quote_d;
        start_q <= start_d;
        pend_q  <= pend_d;
        unbal_q <= unbal_d;
        depth_q <= depth_d;
      end
    end
  end

endmodule

@@ design/sft_queue.sv @@
// Short record queue between front and back of the score field tokenizer.
// Uses sft_pkg.
`timescale 1ns / 1ps

module sft_queue (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  input  sft_pkg::rec_t rec_i,
  output logic          full_o,
  input  logic          pop_i,
  output logic          valid_o,
  output sft_pkg::rec_t rec_o
);
  import sft_pkg::*;

  rec_t             mem_q [QueueDepth];
  logic [QPtrW-1:0] wr_q, rd_q;
  logic [QCntW-1:0] cnt_q;

  assign full_o  = (cnt_q == QCntW'(QueueDepth));
  assign valid_o = (cnt_q != '0);
  assign rec_o   = mem_q[rd_q];

  always_ff @(posedge clk_i) begin
    if (push_i) mem_q[wr_q] <= rec_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push_i) wr_q <= wr_q + 1'b1;
      if (pop_i)  rd_q <= rd_q + 1'b1;
      if (push_i && !pop_i)      cnt_q <= cnt_q + 1'b1;
      else if (pop_i && !push_i) cnt_q <= cnt_q - 1'b1;
    end
  end

endmodule

@@ design/sft_back.sv @@
// Back end of the score field tokenizer: unpacks queue records into single
// results and drives the output register. Uses sft_pkg.
`timescale 1ns / 1ps

module sft_back (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               q_valid_i,
  input  sft_pkg::rec_t      q_rec_i,
  output logic               q_pop_o,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output sft_pkg::out_item_t out_item_o
);
  import sft_pkg::*;

  logic      out_valid_q, sec_valid_q, load;
  out_item_t out_q, sec_q;

  assign load        = !out_valid_q || out_ready_i;
  assign q_pop_o     = load && !sec_valid_q && q_valid_i;
  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;

  always_ff @(posedge clk_i) begin
    if (load && sec_valid_q) out_q <= sec_q;
    else if (q_pop_o)        out_q <= q_rec_i.r0;
    if (q_pop_o)             sec_q <= q_rec_i.r1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      sec_valid_q <= 1'b0;
    end else if (load) begin
      if (sec_valid_q) begin
        out_valid_q <= 1'b1;
        sec_valid_q <= 1'b0;
      end else begin
        out_valid_q <= q_valid_i;
        sec_valid_q <= q_valid_i && q_rec_i.two;
      end
    end
  end

endmodule

@@ design/score_field_tokenizer_top.sv @@
// Top level of the score field tokenizer: front end, record queue, back end.
// Uses sft_pkg, sft_front, sft_queue and sft_back.
`timescale 1ns / 1ps

// Splits a character stream into fields. One character is taken per clock
// whenever the four-entry record queue has room; the front end resolves
// comments, quotes, braces and the blank wait combinationally and writes
// one record of the character's results (one or two), none if it has none.
// The back end hands out one result per cycle through a registered output
// while the output is ready, so a character with two results takes two
// output transfers; the queue absorbs these bursts, and input and output
// stall independently. The mask registers are written on the configuration
// port at any time it is valid (always ready), and are meant to change
// only while the block is idle.
module score_field_tokenizer_top (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  sft_pkg::in_item_t  in_item_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output sft_pkg::out_item_t out_item_o,
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic [1:0]         cfg_index_i,
  input  logic [63:0]        cfg_data_i
);
  import sft_pkg::*;

  logic q_full, q_push, q_pop, q_valid;
  rec_t rec_in, rec_out;

  assign cfg_ready_o = 1'b1;

  sft_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_item_i   (in_item_i),
    .cfg_valid_i (cfg_valid_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .q_full_i    (q_full),
    .q_push_o    (q_push),
    .q_rec_o     (rec_in)
  );

  // Records of one transfer each; decouples the character side from the
  // result side.
  sft_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (q_push),
    .rec_i   (rec_in),
    .full_o  (q_full),
    .pop_i   (q_pop),
    .valid_o (q_valid),
    .rec_o   (rec_out)
  );

  sft_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .q_valid_i   (q_valid),
    .q_rec_i     (rec_out),
    .q_pop_o     (q_pop),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_item_o  (out_item_o)
  );

endmodule
